// ===== design/hsm_pkg.sv =====
`timescale 1ns / 1ps
// shared codes and types for the hashed key set
package hsm_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUP       = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic       found;
      status_type status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_KEY,
      FR_SQUARE,
      FR_SQ_RED,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MASK,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

endpackage

// ===== design/hsm_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module hsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/hsm_queue.sv =====
`timescale 1ns / 1ps
// two-entry queue of words
module hsm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/hsm_front.sv =====
`timescale 1ns / 1ps
// front end: accepts requests and works out the bucket as key squared mod bucket count
module hsm_front import hsm_pkg::*; #(
   parameter int NUM_BUCKETS = 7,
   parameter int KEY_BITS    = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [1:0]                     req_kind,
   input  logic [KEY_BITS-1:0]            req_key,
   output logic                           item_push,
   input  logic                           item_full,
   output logic [1:0]                     item_kind,
   output logic [KEY_BITS-1:0]            item_key,
   output logic [$clog2(NUM_BUCKETS)-1:0] item_bucket
);

   localparam int BW        = $clog2(NUM_BUCKETS);
   localparam int DIG       = 4;
   localparam int KEY_STEPS = (KEY_BITS + DIG - 1) / DIG;
   localparam int SQ_STEPS  = (2 * BW + DIG - 1) / DIG;
   localparam int MAX_STEPS = (KEY_STEPS > SQ_STEPS) ? KEY_STEPS : SQ_STEPS;
   localparam int SHW       = MAX_STEPS * DIG;
   localparam int CW        = $clog2(MAX_STEPS + 1);
   localparam logic [BW:0] NBW = (BW + 1)'(NUM_BUCKETS);

   front_state_type     state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SHW-1:0]      sh_ff, sh_in;
   logic [BW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [2*BW-1:0]     sq;

   // shift DIG bits into a remainder that stays below the bucket count
   function automatic logic [BW-1:0] reduce(input logic [BW-1:0] r,
                                            input logic [DIG-1:0] d);
      logic [BW:0]   t;
      logic [BW-1:0] acc;
      acc = r;
      for (int i = 0; i < DIG; i++) begin
         t = {acc, d[DIG-1-i]};
         if (t >= NBW) begin
            t = t - NBW;
         end
         acc = t[BW-1:0];
      end
      return acc;
   endfunction

   assign sq          = (2*BW)'(rem_ff) * (2*BW)'(rem_ff);
   assign item_kind   = kind_ff;
   assign item_key    = key_ff;
   assign item_bucket = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      key_ff  <= key_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      sh_in     = sh_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      full      = 1'b1;
      item_push = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            full = 1'b0;
            if (push) begin
               kind_in  = req_kind;
               key_in   = req_key;
               sh_in    = SHW'(req_key) << (SHW - KEY_STEPS * DIG);
               rem_in   = '0;
               cnt_in   = CW'(KEY_STEPS);
               state_in = FR_KEY;
            end
         end
         FR_KEY, FR_SQ_RED: begin
            rem_in = reduce(rem_ff, sh_ff[SHW-1 -: DIG]);
            sh_in  = sh_ff << DIG;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = (state_ff == FR_KEY) ? FR_SQUARE : FR_PUSH;
            end
         end
         FR_SQUARE: begin
            // (k mod n)^2 mod n equals k^2 mod n
            sh_in    = SHW'(sq) << (SHW - SQ_STEPS * DIG);
            rem_in   = '0;
            cnt_in   = CW'(SQ_STEPS);
            state_in = FR_SQ_RED;
         end
         FR_PUSH: begin
            item_push = !item_full;
            if (!item_full) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

endmodule

// ===== design/hsm_back.sv =====
`timescale 1ns / 1ps
// back end: scans the bucket slots and applies insert, search or delete
module hsm_back import hsm_pkg::*; #(
   parameter int NUM_BUCKETS      = 7,
   parameter int SLOTS_PER_BUCKET = 8,
   parameter int KEY_BITS         = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_empty,
   output logic                           item_pop,
   input  logic [1:0]                     item_kind,
   input  logic [KEY_BITS-1:0]            item_key,
   input  logic [$clog2(NUM_BUCKETS)-1:0] item_bucket,
   output logic                           rsp_push,
   output rsp_word_type                   rsp_word,
   input  logic                           rsp_full
);

   localparam int BW  = $clog2(NUM_BUCKETS);
   localparam int SIW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int AW  = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET);
   localparam int S   = SLOTS_PER_BUCKET;

   back_state_type      state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [BW-1:0]       bucket_ff, bucket_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [SIW-1:0]      slot_ff, slot_in;
   logic [SIW-1:0]      hit_slot_ff, hit_slot_in;
   logic                hit_ff, hit_in;
   logic [S-1:0]        mask_ff, mask_in;
   logic [NUM_BUCKETS-1:0] row_ok_ff, row_ok_in;

   logic                mask_we;
   logic [S-1:0]        mask_wdata, mask_q;
   logic [BW-1:0]       mask_raddr;
   logic                key_we;
   logic [AW-1:0]       key_waddr, key_raddr;
   logic [KEY_BITS-1:0] key_q;
   logic                free_any;
   logic [SIW-1:0]      free_slot;
   logic                match;

   hsm_ram #(.WIDTH(S), .DEPTH(NUM_BUCKETS)) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .waddr (bucket_ff),
      .wdata (mask_wdata),
      .raddr (mask_raddr),
      .rdata (mask_q)
   );

   hsm_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_BUCKETS * SLOTS_PER_BUCKET)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_ff),
      .raddr (key_raddr),
      .rdata (key_q)
   );

   // lowest empty slot
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = S - 1; i >= 0; i--) begin
         if (!mask_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SIW'(i);
         end
      end
   end

   assign match     = mask_ff[slot_ff] && (key_q == key_ff);
   assign key_waddr = base_ff + AW'(free_slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         row_ok_ff <= '0;
      end else begin
         state_ff  <= state_in;
         row_ok_ff <= row_ok_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      bucket_ff   <= bucket_in;
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      hit_slot_ff <= hit_slot_in;
      hit_ff      <= hit_in;
      mask_ff     <= mask_in;
   end

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      key_in          = key_ff;
      bucket_in       = bucket_ff;
      base_in         = base_ff;
      slot_in         = slot_ff;
      hit_slot_in     = hit_slot_ff;
      hit_in          = hit_ff;
      mask_in         = mask_ff;
      row_ok_in       = row_ok_ff;
      item_pop        = 1'b0;
      mask_raddr      = item_bucket;
      mask_we         = 1'b0;
      mask_wdata      = mask_ff;
      key_we          = 1'b0;
      key_raddr       = base_ff;
      rsp_push        = 1'b0;
      rsp_word.found  = hit_ff;
      rsp_word.status = ST_OK;
      case (state_ff)
         BK_IDLE: begin
            if (!item_empty) begin
               item_pop  = 1'b1;
               kind_in   = item_kind;
               key_in    = item_key;
               bucket_in = item_bucket;
               base_in   = AW'(item_bucket) * AW'(S);
               state_in  = BK_MASK;
            end
         end
         BK_MASK: begin
            // a row never written reads as all slots empty
            mask_in     = row_ok_ff[bucket_ff] ? mask_q : '0;
            slot_in     = '0;
            hit_in      = 1'b0;
            hit_slot_in = '0;
            key_raddr   = base_ff;
            state_in    = BK_SCAN;
         end
         BK_SCAN: begin
            key_raddr = base_ff + AW'(slot_ff) + AW'(1);
            if (match) begin
               hit_in      = 1'b1;
               hit_slot_in = slot_ff;
               state_in    = BK_FINISH;
            end else if (slot_ff == SIW'(S - 1)) begin
               state_in = BK_FINISH;
            end else begin
               slot_in = slot_ff + SIW'(1);
            end
         end
         BK_FINISH: begin
            case (kind_ff)
               KIND_INSERT: begin
                  if (hit_ff) begin
                     rsp_word.status = ST_DUP;
                  end else if (free_any) begin
                     rsp_word.status = ST_OK;
                     mask_wdata      = mask_ff | (S'(1) << free_slot);
                     mask_we         = !rsp_full;
                     key_we          = !rsp_full;
                  end else begin
                     rsp_word.status = ST_FULL;
                  end
               end
               KIND_DELETE: begin
                  if (hit_ff) begin
                     rsp_word.status = ST_OK;
                     mask_wdata      = mask_ff & ~(S'(1) << hit_slot_ff);
                     mask_we         = !rsp_full;
                  end else begin
                     rsp_word.status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_word.status = hit_ff ? ST_OK : ST_NOT_FOUND;
               end
            endcase
            if (mask_we) begin
               row_ok_in[bucket_ff] = 1'b1;
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

endmodule

// ===== design/hash_set_square_mod_buckets.sv =====
`timescale 1ns / 1ps
// top level of the hashed key set with square-mod bucket selection
//
// request side: push a word of req_kind (insert, search, delete) and req_key
// while full is low. result side: while empty is low, rsp_found and
// rsp_status hold the oldest result word; pop takes it.
// one result word comes out for every request word, in request order.
// the front end reduces the key mod the bucket count four bits a cycle, then
// squares the remainder and reduces again.
// the back end reads the bucket's valid mask, then compares one stored slot
// per cycle against the key through the key ram read port, stopping at a hit.
// a two-word queue sits between the two ends, so a new request is taken while
// the back end is busy; sustained rate is one word per front end pass or back
// end scan, whichever is longer.
// reset empties every bucket at once; no clearing pass is needed.
// when pop stays low the two-word result queue fills, the back end holds its
// finished word without touching the table, then the front end stalls and
// full rises.
module hash_set_square_mod_buckets import hsm_pkg::*; #(
   parameter int NUM_BUCKETS      = 7,
   parameter int SLOTS_PER_BUCKET = 8,
   parameter int KEY_BITS         = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          req_kind,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_found,
   output logic [1:0]          rsp_status
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int IW = 2 + KEY_BITS + BW;

   logic                item_push, item_full, item_pop, item_empty;
   logic [1:0]          f_kind, b_kind;
   logic [KEY_BITS-1:0] f_key, b_key;
   logic [BW-1:0]       f_bucket, b_bucket;
   logic [IW-1:0]       item_rdata;
   logic                rsp_push, rsp_full;
   rsp_word_type        rsp_wword, rsp_rword;

   hsm_front #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_kind    (req_kind),
      .req_key     (req_key),
      .item_push   (item_push),
      .item_full   (item_full),
      .item_kind   (f_kind),
      .item_key    (f_key),
      .item_bucket (f_bucket)
   );

   hsm_queue #(.WIDTH(IW)) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .wdata ({f_kind, f_key, f_bucket}),
      .full  (item_full),
      .pop   (item_pop),
      .rdata (item_rdata),
      .empty (item_empty)
   );

   assign {b_kind, b_key, b_bucket} = item_rdata;

   hsm_back #(
      .NUM_BUCKETS      (NUM_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
      .KEY_BITS         (KEY_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .item_kind   (b_kind),
      .item_key    (b_key),
      .item_bucket (b_bucket),
      .rsp_push    (rsp_push),
      .rsp_word    (rsp_wword),
      .rsp_full    (rsp_full)
   );

   hsm_queue #(.WIDTH($bits(rsp_word_type))) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wword),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rword),
      .empty (empty)
   );

   assign rsp_found  = rsp_rword.found;
   assign rsp_status = rsp_rword.status;

`ifndef ASSERT_OFF
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result word pushed into a full queue");

   a_item_no_overrun: assert property (@(posedge clock) disable iff (reset)
      item_push |-> !item_full)
      else $error("request word pushed into a full middle queue");

   a_item_no_underrun: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> !item_empty)
      else $error("back end popped an empty middle queue");
`endif

endmodule

// ===== tb/key_set_checker.sv =====
`timescale 1ns / 1ps
// predicts and checks the result words of the hashed key set from its two channels
module key_set_checker import hsm_pkg::*; #(
   parameter int NUM_BUCKETS      = 7,
   parameter int SLOTS_PER_BUCKET = 8,
   parameter int KEY_BITS         = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                full,
   input  logic [1:0]          req_kind,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic                empty,
   input  logic                pop,
   input  logic                rsp_found,
   input  logic [1:0]          rsp_status,
   output int                  failures,
   output int                  words_checked
);

   typedef struct {
      logic [1:0]          kind;
      logic [KEY_BITS-1:0] key;
      rsp_word_type        word;
   } due_answer_type;

   logic [KEY_BITS-1:0]         stored_key [NUM_BUCKETS][SLOTS_PER_BUCKET];
   logic [SLOTS_PER_BUCKET-1:0] slot_used [NUM_BUCKETS];
   due_answer_type              answers_due [$];
   due_answer_type              oldest_answer;
   due_answer_type              new_answer;
   int                          mismatches = 0;
   int                          outstanding = 0;
   int                          word_index = 0;

   assign failures = mismatches + outstanding;

   function automatic rsp_word_type apply_to_key_set(input logic [1:0] kind,
                                                     input logic [KEY_BITS-1:0] key);
      rsp_word_type ans;
      int unsigned  sq;
      int           b;
      int           hit;
      int           free_slot;
      sq = key;
      sq = sq * sq;
      b = sq % NUM_BUCKETS;
      hit = -1;
      free_slot = -1;
      // scan downward so the lowest matching and lowest free slot win
      for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
         if (slot_used[b][s] && stored_key[b][s] == key) hit = s;
         if (!slot_used[b][s]) free_slot = s;
      end
      ans.found = (hit >= 0);
      case (kind)
         KIND_INSERT: begin
            if (hit >= 0) begin
               ans.status = ST_DUP;
            end else if (free_slot < 0) begin
               ans.status = ST_FULL;
            end else begin
               stored_key[b][free_slot] = key;
               slot_used[b][free_slot] = 1'b1;
               ans.status = ST_OK;
            end
         end
         KIND_DELETE: begin
            if (hit >= 0) begin
               slot_used[b][hit] = 1'b0;
               ans.status = ST_OK;
            end else begin
               ans.status = ST_NOT_FOUND;
            end
         end
         default: begin
            // search, and the spare kind code behaves the same
            if (hit >= 0) ans.status = ST_OK;
            else ans.status = ST_NOT_FOUND;
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) slot_used[b] = '0;
         answers_due.delete();
         outstanding = 0;
         words_checked <= 0;
      end else begin
         if (pop && !empty) begin
            words_checked <= words_checked + 1;
            word_index++;
            if (answers_due.size() == 0) begin
               if (mismatches < 10)
                  $display("word %0d: no result expected, got found %0b status %0d",
                           word_index, rsp_found, rsp_status);
               mismatches++;
            end else begin
               oldest_answer = answers_due.pop_front();
               if (rsp_found !== oldest_answer.word.found ||
                   rsp_status !== oldest_answer.word.status) begin
                  if (mismatches < 10)
                     $display("word %0d (kind %0d key %0d): expected %0b/%0d, got %0b/%0d",
                              word_index, oldest_answer.kind, oldest_answer.key,
                              oldest_answer.word.found, oldest_answer.word.status,
                              rsp_found, rsp_status);
                  mismatches++;
               end
            end
         end
         if (push && !full) begin
            new_answer.kind = req_kind;
            new_answer.key = req_key;
            new_answer.word = apply_to_key_set(req_kind, req_key);
            answers_due.push_back(new_answer);
         end
         outstanding = answers_due.size();
      end
   end

endmodule

// ===== tb/tb_hash_set_square_mod_buckets.sv =====
`timescale 1ns / 1ps
// drives requests and result pops into the hashed key set and reports the verdict
module tb_hash_set_square_mod_buckets;
   import hsm_pkg::*;

   localparam int         NUM_BUCKETS      = 7;
   localparam int         SLOTS_PER_BUCKET = 8;
   localparam int         KEY_BITS         = 15;
   localparam logic [1:0] KIND_SPARE       = 2'd3;
   localparam int         POOL_SIZE        = 40;
   localparam int         PHASE_WORDS      = 375;
   localparam int         CYCLE_LIMIT      = 400000;
   localparam int         SETTLE_CYCLES    = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                pop = 1'b0;
   logic [1:0]          req_kind = KIND_INSERT;
   logic [KEY_BITS-1:0] req_key = '0;
   logic                full;
   logic                empty;
   logic                rsp_found;
   logic [1:0]          rsp_status;

   int                  failures;
   int                  words_checked;
   int                  words_sent = 0;
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  cycle_count = 0;
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   always #5 clock = ~clock;

   hash_set_square_mod_buckets #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
      .KEY_BITS(KEY_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_kind(req_kind),
      .req_key(req_key),
      .empty(empty),
      .pop(pop),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status)
   );

   key_set_checker #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
      .KEY_BITS(KEY_BITS)
   ) results_check (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_kind(req_kind),
      .req_key(req_key),
      .empty(empty),
      .pop(pop),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status),
      .failures(failures),
      .words_checked(words_checked)
   );

   always @(posedge clock) begin
      pop <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic [KEY_BITS-1:0] key);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_kind <= kind;
      req_key <= key;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (words_checked < words_sent) @(posedge clock);
   endtask

   initial begin
      int                  pick;
      logic [1:0]          kind;
      logic [KEY_BITS-1:0] key;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 6; i++) key_pool[i] = KEY_BITS'(7 * $urandom_range(0, 4681));
      for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extremes, duplicates, absent keys, spare kind, then overfill bucket zero
      send_word(KIND_INSERT, '0);
      send_word(KIND_INSERT, '1);
      send_word(KIND_INSERT, '0);
      send_word(KIND_SEARCH, '1);
      send_word(KIND_SEARCH, 15'd5);
      send_word(KIND_SPARE, '1);
      send_word(KIND_DELETE, '0);
      send_word(KIND_DELETE, '0);
      for (int k = 1; k <= 8; k++) begin
         key = KEY_BITS'(7 * k);
         send_word(KIND_INSERT, key);
      end
      send_word(KIND_DELETE, 15'd28);
      send_word(KIND_INSERT, 15'd70);
      send_word(KIND_SEARCH, 15'd70);
      send_word(KIND_SEARCH, 15'd56);
      send_word(KIND_SPARE, 15'd1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 73;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 73;
            end
            default: begin
               idle_pct = 11;
               stall_pct <= 11;
            end
         endcase
         repeat (PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // stray keys, rarely inserted so the pool keeps its buckets
               key = KEY_BITS'($urandom);
               pick = $urandom_range(19);
               if (pick == 0) kind = KIND_INSERT;
               else if (pick < 8) kind = KIND_SEARCH;
               else if (pick < 16) kind = KIND_DELETE;
               else kind = KIND_SPARE;
            end else begin
               key = key_pool[$urandom_range(POOL_SIZE - 1)];
               pick = $urandom_range(99);
               if (pick < 38) kind = KIND_INSERT;
               else if (pick < 68) kind = KIND_SEARCH;
               else if (pick < 96) kind = KIND_DELETE;
               else kind = KIND_SPARE;
            end
            send_word(kind, key);
         end
         wait_drained();
      end

      stall_pct <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
